FILE: design/vhrc_pkg.sv
package vhrc_pkg;

  localparam int EMP_W = 10;
  localparam int VAL_W = 12;
  localparam int CNT_W = 11;

  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_COUNT = 1'b1;

  localparam logic [1:0] OP_INC   = 2'd0;
  localparam logic [1:0] OP_DEC   = 2'd1;
  localparam logic [1:0] OP_RANGE = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
    logic       ack;
  } tree_req_t;

  typedef struct packed {
    logic ready;
    logic done;
    logic res_valid;
  } tree_sts_t;

endpackage

FILE: design/vhrc_in_if.sv
interface vhrc_in_if;
  import vhrc_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [EMP_W-1:0] employee;
  logic [VAL_W-1:0] salary;
  logic [VAL_W-1:0] range_low;
  logic [VAL_W-1:0] range_high;

  modport source (output valid, cmd, employee, salary, range_low, range_high, input ready);
  modport sink (input valid, cmd, employee, salary, range_low, range_high, output ready);
endinterface

FILE: design/vhrc_out_if.sv
interface vhrc_out_if;
  import vhrc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] count;

  modport source (output valid, count, input ready);
  modport sink (input valid, count, output ready);
endinterface

FILE: design/value_histogram_range_count.sv
// Set transaction: the single-read-port tree RAM is walked leaf to root once to remove the old
// salary and once to add the new one; for an empty slot only the add walk is made.
// Count transaction: the range walk climbs root-ward through the tree, with a T_RA and a T_RB
// step per level, up to the result register. One transaction is in work at a time. Reset clears
// the employee table and the tree, accepting nothing while it does.
module value_histogram_range_count #(
  parameter int EMPLOYEES  = 1024,
  parameter int VALUE_BITS = 12
) (
  input logic       clk,
  input logic       rst,
  vhrc_in_if.sink   items,
  vhrc_out_if.source results
);
  import vhrc_pkg::*;

  localparam int SW = $clog2(EMPLOYEES);
  localparam int EW = $clog2(EMPLOYEES + 1);
  localparam int CW = (EW > CNT_W) ? EW : CNT_W;
  localparam logic [31:0] VMAX = (32'd1 << VALUE_BITS) - 32'd1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_DEC  = 3'd2;
  localparam logic [2:0] ST_INC  = 3'd3;
  localparam logic [2:0] ST_CNT  = 3'd4;

  function automatic logic [VALUE_BITS-1:0] clampv(input logic [VAL_W-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    if (w > VMAX) begin
      w = VMAX;
    end
    return w[VALUE_BITS-1:0];
  endfunction

  logic [2:0]            state;
  logic                  clr_busy;
  logic [SW-1:0]         clr_addr;
  logic [SW-1:0]         slot;
  logic [VALUE_BITS-1:0] val_q;
  logic                  out_valid;
  logic [CNT_W-1:0]      out_count;

  logic                  accept;
  logic [31:0]           emp_w;
  logic                  slot_ok;
  logic                  out_free;
  logic                  slot_we;
  logic [SW-1:0]         slot_waddr;
  logic [VALUE_BITS:0]   slot_wdata;
  logic [VALUE_BITS:0]   slot_rdata;
  tree_req_t             tree_req;
  tree_sts_t             tree_sts;
  logic [VALUE_BITS-1:0] tree_value;
  logic [CW-1:0]         tree_result;

  // Each slot entry holds a present bit above the stored salary.
  vhrc_ram #(.WIDTH(VALUE_BITS + 1), .DEPTH(EMPLOYEES)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (emp_w[SW-1:0]),
    .rdata (slot_rdata)
  );

  vhrc_tree #(.VALUE_BITS(VALUE_BITS), .CW(CW)) u_tree (
    .clk    (clk),
    .rst    (rst),
    .req    (tree_req),
    .value  (tree_value),
    .low    (clampv(items.range_low)),
    .high   (clampv(items.range_high)),
    .sts    (tree_sts),
    .result (tree_result)
  );

  always_comb begin
    items.ready = (state == ST_IDLE) && !clr_busy && tree_sts.ready;
    accept      = items.valid && items.ready;
    emp_w       = 32'(items.employee);
    slot_ok     = emp_w < 32'(EMPLOYEES);
    out_free    = !out_valid || results.ready;

    slot_we    = 1'b0;
    slot_waddr = slot;
    slot_wdata = {1'b1, val_q};
    if (clr_busy) begin
      slot_we    = 1'b1;
      slot_waddr = clr_addr;
      slot_wdata = '0;
    end else if (state == ST_RD) begin
      slot_we = 1'b1;
    end

    tree_req.start = (accept && (items.cmd == CMD_COUNT)) || (state == ST_RD)
                     || (state == ST_DEC && tree_sts.done);
    if (accept) begin
      tree_req.op = OP_RANGE;
    end else if (state == ST_RD && slot_rdata[VALUE_BITS]) begin
      tree_req.op = OP_DEC;
    end else begin
      tree_req.op = OP_INC;
    end
    tree_req.ack = (state == ST_CNT) && tree_sts.res_valid && out_free;

    tree_value = (state == ST_RD && slot_rdata[VALUE_BITS]) ?
                 slot_rdata[VALUE_BITS-1:0] : val_q;

    results.valid = out_valid;
    results.count = out_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      clr_busy  <= 1'b1;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + SW'(1);
        if (32'(clr_addr) == 32'(EMPLOYEES - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      if (tree_req.ack) begin
        out_valid <= 1'b1;
        out_count <= tree_result[CNT_W-1:0];
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (items.cmd == CMD_SET) begin
              // A slot beyond the table is dropped without any update.
              if (slot_ok) begin
                slot  <= emp_w[SW-1:0];
                val_q <= clampv(items.salary);
                state <= ST_RD;
              end
            end else begin
              state <= ST_CNT;
            end
          end
        end
        ST_RD:  state <= slot_rdata[VALUE_BITS] ? ST_DEC : ST_INC;
        ST_DEC: if (tree_sts.done) state <= ST_INC;
        ST_INC: if (tree_sts.done) state <= ST_IDLE;
        ST_CNT: if (tree_req.ack) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_when_clear: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!clr_busy && tree_sts.ready))
    else $error("transaction accepted while a sweep or tree operation is active");

  a_done_in_update: assert property (@(posedge clk) disable iff (rst)
    tree_sts.done |-> (state == ST_DEC || state == ST_INC))
    else $error("tree update finished outside a set");

  a_result_in_count: assert property (@(posedge clk) disable iff (rst)
    tree_sts.res_valid |-> (state == ST_CNT))
    else $error("range result present outside a count");

  a_out_from_count: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_CNT))
    else $error("result loaded without a count in work");

endmodule

FILE: design/vhrc_ram.sv
module vhrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/vhrc_tree.sv
module vhrc_tree #(
  parameter int VALUE_BITS = 12,
  parameter int CW = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  vhrc_pkg::tree_req_t       req,
  input  logic [VALUE_BITS-1:0]     value,
  input  logic [VALUE_BITS-1:0]     low,
  input  logic [VALUE_BITS-1:0]     high,
  output vhrc_pkg::tree_sts_t       sts,
  output logic [CW-1:0]             result
);
  import vhrc_pkg::*;

  localparam int AW = VALUE_BITS + 1;
  localparam int LW = VALUE_BITS + 2;

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_ADJ  = 3'd1;
  localparam logic [2:0] T_RA   = 3'd2;
  localparam logic [2:0] T_RB   = 3'd3;
  localparam logic [2:0] T_RES  = 3'd4;

  logic [2:0]    state;
  logic          clr_busy;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] cur;
  logic [AW-1:0] wnode;
  logic          pend;
  logic          dec;
  logic          skip;
  logic [LW-1:0] l;
  logic [LW-1:0] r;
  logic [CW-1:0] sum;
  logic          done;

  logic          we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [CW-1:0] rdata;
  logic [AW-1:0] leaf;
  logic [LW-1:0] r_dec;
  logic [CW-1:0] sum_add;
  logic          skip_eff;

  vhrc_ram #(.WIDTH(CW), .DEPTH(2 ** AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    leaf    = {1'b1, value};
    r_dec   = r - LW'(1);
    sum_add = sum + (pend ? rdata : '0);
    // A decrement of an empty leaf leaves the whole path untouched.
    skip_eff = skip || (wnode[AW-1] && dec && (rdata == '0));
    we    = 1'b0;
    waddr = wnode;
    wdata = dec ? (rdata - CW'(1)) : (rdata + CW'(1));
    raddr = cur;
    case (state)
      T_IDLE: raddr = leaf;
      T_ADJ:  we = pend && !skip_eff;
      T_RA:   raddr = l[AW-1:0];
      T_RB:   raddr = r_dec[AW-1:0];
      default: raddr = cur;
    endcase
    if (clr_busy) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      clr_busy <= 1'b1;
      clr_addr <= '0;
      pend     <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (clr_busy) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == '1) begin
          clr_busy <= 1'b0;
        end
      end
      case (state)
        T_IDLE: begin
          pend <= 1'b0;
          if (req.start && !clr_busy) begin
            case (req.op)
              OP_INC, OP_DEC: begin
                dec   <= (req.op == OP_DEC);
                skip  <= 1'b0;
                pend  <= 1'b1;
                wnode <= leaf;
                cur   <= leaf >> 1;
                state <= T_ADJ;
              end
              OP_RANGE: begin
                l     <= {2'b01, low};
                r     <= {2'b01, high} + LW'(1);
                sum   <= '0;
                state <= T_RA;
              end
              default: state <= T_IDLE;
            endcase
          end
        end
        T_ADJ: begin
          // Write back the node read last cycle while reading its parent.
          skip <= skip_eff;
          if (cur != '0) begin
            pend  <= 1'b1;
            wnode <= cur;
            cur   <= cur >> 1;
          end else begin
            pend <= 1'b0;
          end
          if (pend && (wnode == AW'(1))) begin
            state <= T_IDLE;
            done  <= 1'b1;
          end
        end
        T_RA: begin
          sum <= sum_add;
          if (l < r) begin
            if (l[0]) begin
              pend <= 1'b1;
              l    <= l + LW'(1);
            end else begin
              pend <= 1'b0;
            end
            state <= T_RB;
          end else begin
            result <= sum_add;
            pend   <= 1'b0;
            state  <= T_RES;
          end
        end
        T_RB: begin
          sum <= sum_add;
          if (r[0]) begin
            pend <= 1'b1;
            r    <= r_dec >> 1;
          end else begin
            pend <= 1'b0;
            r    <= r >> 1;
          end
          l     <= l >> 1;
          state <= T_RA;
        end
        T_RES: begin
          if (req.ack) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  always_comb begin
    sts.ready     = (state == T_IDLE) && !clr_busy;
    sts.done      = done;
    sts.res_valid = (state == T_RES);
  end

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (state == T_ADJ && we) |-> (raddr != waddr))
    else $error("tree walk reads the node it writes");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("update done held for more than one cycle");

  a_res_settled: assert property (@(posedge clk) disable iff (rst)
    (state == T_RES) |-> !pend)
    else $error("range result shown with a read still in flight");

endmodule

FILE: dv/value_histogram_range_count_tb.sv
`timescale 1ns / 100ps

module value_histogram_range_count_tb;
  import vhrc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 2 * (VAL_W + 2) + 12;

  // Tracks per-slot salaries and a histogram of salary values, and predicts the
  // range count for every count transaction.
  class salary_histogram;
    logic [VAL_W-1:0] slot_salary [1 << EMP_W];
    bit               slot_taken [1 << EMP_W];
    int unsigned      per_value [1 << VAL_W];
    logic [CNT_W-1:0] pending_counts [$];
    int               errors;
    int               sets_seen;
    int               ranges_seen;
    int               counts_checked;
    int               slots_filled;

    function void apply_item(logic cmd, logic [EMP_W-1:0] employee, logic [VAL_W-1:0] salary,
                             logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
      int unsigned total;
      if (cmd == CMD_SET) begin
        if (slot_taken[employee]) begin
          if (per_value[slot_salary[employee]] > 0) per_value[slot_salary[employee]]--;
        end else begin
          slots_filled++;
        end
        slot_salary[employee] = salary;
        slot_taken[employee] = 1'b1;
        per_value[salary]++;
        sets_seen++;
      end else begin
        total = 0;
        if (lo <= hi) begin
          for (int v = int'(lo); v <= int'(hi); v++) total += per_value[v];
        end
        pending_counts = {pending_counts, total[CNT_W-1:0]};
        ranges_seen++;
      end
    endfunction

    function void check_count(logic [CNT_W-1:0] actual);
      logic [CNT_W-1:0] wanted;
      if (pending_counts.size() == 0) begin
        $error("count: result %0d arrived with no transaction waiting for it", actual);
        errors++;
      end else begin
        wanted = pending_counts.pop_front();
        counts_checked++;
        if (actual !== wanted) begin
          $error("count: expected %0d, actual %0d", wanted, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm;
  int   cycle_count;
  salary_histogram histogram;

  vhrc_in_if  items_if();
  vhrc_out_if results_if();

  value_histogram_range_count #(
    .EMPLOYEES (1 << EMP_W),
    .VALUE_BITS(VAL_W)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .items  (items_if),
    .results(results_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_item(input logic cmd, input logic [EMP_W-1:0] employee,
                           input logic [VAL_W-1:0] salary, input logic [VAL_W-1:0] lo,
                           input logic [VAL_W-1:0] hi);
    @(negedge clk);
    items_if.valid <= 1'b1;
    items_if.cmd <= cmd;
    items_if.employee <= employee;
    items_if.salary <= salary;
    items_if.range_low <= lo;
    items_if.range_high <= hi;
    @(posedge clk);
    while (items_if.ready !== 1'b1) @(posedge clk);
    histogram.apply_item(cmd, employee, salary, lo, hi);
  endtask

  task automatic pause_items(input int cycles);
    @(negedge clk);
    items_if.valid <= 1'b0;
    repeat (cycles - 1) @(posedge clk);
  endtask

  // The sink side holds ready low at random, with a 38 percent chance, except in the calm stretch.
  always @(negedge clk) begin
    results_if.ready <= calm || ($urandom_range(0, 99) >= 38);
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
      histogram.check_count(results_if.count);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("value_histogram_range_count_tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic             cmd;
    logic [EMP_W-1:0] emp;
    logic [VAL_W-1:0] sal;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] swap;
    int               op_roll;

    rst = 1'b1;
    calm = 1'b0;
    items_if.valid = 1'b0;
    items_if.cmd = CMD_SET;
    items_if.employee = '0;
    items_if.salary = '0;
    items_if.range_low = '0;
    items_if.range_high = '0;
    histogram = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty tree, salaries at both ends of the value range, reassignment
    // of a slot, a repeat of the same salary, and ranges that are empty.
    send_item(CMD_COUNT, 10'd0, 12'd0, 12'd0, 12'hFFF);
    send_item(CMD_SET, 10'd0, 12'd0, 12'hFFF, 12'hFFF);
    send_item(CMD_SET, 10'h3FF, 12'hFFF, 12'd0, 12'd0);
    send_item(CMD_SET, 10'h2AA, 12'hAAA, 12'h555, 12'hAAA);
    send_item(CMD_SET, 10'h155, 12'h555, 12'hAAA, 12'h555);
    send_item(CMD_COUNT, 10'h3FF, 12'hFFF, 12'd0, 12'd0);
    send_item(CMD_COUNT, 10'h000, 12'h000, 12'hFFF, 12'hFFF);
    send_item(CMD_COUNT, 10'h2AA, 12'hAAA, 12'd0, 12'hFFF);
    send_item(CMD_COUNT, 10'h155, 12'h555, 12'hFFF, 12'd0);
    send_item(CMD_COUNT, 10'd0, 12'd0, 12'd1, 12'hFFE);
    send_item(CMD_SET, 10'd0, 12'hFFF, 12'd0, 12'd0);
    send_item(CMD_COUNT, 10'd0, 12'd0, 12'd0, 12'd0);
    send_item(CMD_COUNT, 10'd0, 12'd0, 12'hFFF, 12'hFFF);
    send_item(CMD_SET, 10'd0, 12'hFFF, 12'd0, 12'd0);
    send_item(CMD_COUNT, 10'd0, 12'd0, 12'hFFF, 12'hFFF);
    send_item(CMD_COUNT, 10'd0, 12'd0, 12'hAAA, 12'hAAA);
    send_item(CMD_COUNT, 10'd0, 12'd0, 12'hAAB, 12'hAAA);
    send_item(CMD_SET, 10'h155, 12'hAAA, 12'd0, 12'd0);
    send_item(CMD_COUNT, 10'd0, 12'd0, 12'h555, 12'hAAA);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 350 && n < 600);
      op_roll = $urandom_range(0, 99);
      // A small pool of slots gets reassigned often; a cluster of salaries makes counts large.
      emp = ($urandom_range(0, 3) == 0) ? EMP_W'($urandom_range(0, 31)) : EMP_W'($urandom());
      sal = ($urandom_range(0, 2) == 0) ? VAL_W'($urandom_range(2000, 2100))
                                        : VAL_W'($urandom());
      lo = VAL_W'($urandom());
      hi = VAL_W'($urandom());
      if (op_roll < 55) begin
        cmd = CMD_SET;
      end else begin
        cmd = CMD_COUNT;
        case ($urandom_range(0, 4))
          0: begin
            if (lo > hi) begin
              swap = lo;
              lo = hi;
              hi = swap;
            end
          end
          1: ;
          2: begin
            lo = VAL_W'($urandom_range(1995, 2105));
            hi = lo;
          end
          3: begin
            lo = VAL_W'($urandom_range(1990, 2050));
            hi = VAL_W'($urandom_range(2040, 2110));
          end
          default: begin
            if ($urandom_range(0, 1) == 0) lo = '0;
            else hi = '1;
          end
        endcase
      end
      send_item(cmd, emp, sal, lo, hi);
      if (!calm && $urandom_range(0, 99) < 38) begin
        pause_items(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4));
      end
    end

    calm = 1'b0;
    @(negedge clk);
    items_if.valid <= 1'b0;
    while (histogram.pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d set and %0d range count transactions, %0d results checked",
             histogram.sets_seen, histogram.ranges_seen, histogram.counts_checked);
    $display("%0d employee slots held a salary at the end, %0d mismatches",
             histogram.slots_filled, histogram.errors);
    if (histogram.errors == 0) begin
      $display("value_histogram_range_count_tb: done, clean");
    end else begin
      $display("value_histogram_range_count_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
design/vhrc_pkg.sv
design/vhrc_in_if.sv
design/vhrc_out_if.sv
design/vhrc_ram.sv
design/vhrc_tree.sv
design/value_histogram_range_count.sv
dv/value_histogram_range_count_tb.sv
